@@ rtl/core/bta_pkg.sv @@
// Shared constants, codes and types of the block table allocator.
// Depends on nothing; imported by block_table_allocator.
`timescale 1ns / 1ps

package bta_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int NUM_BANKS   = 5;
  localparam int MEM_DEPTH   = NUM_BANKS * TABLE_DEPTH;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W       = LEN_W;

  // field widths
  localparam int CMD_W     = 2;
  localparam int BANK_W    = 3;
  localparam int SIZE_W    = 24;
  localparam int NEED_W    = SIZE_W + 1;
  localparam int STAT_W    = 2;
  localparam int PERM_W    = 10;
  localparam int LG_W      = 4;
  localparam int TE_W      = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = TE_W;

  // arithmetic limits
  localparam int MAX_BS_LOG2 = 12;
  localparam int PERMILLE    = 1000;
  localparam int LIM_W       = LEN_W + MAX_BS_LOG2;
  localparam int OCMP_W      = (LIM_W > SIZE_W) ? LIM_W : SIZE_W;
  localparam int AOFF_W      = IDX_W + MAX_BS_LOG2;
  localparam int DIV_W       = $clog2(TABLE_DEPTH * PERMILLE + 1);
  localparam int DCNT_W      = $clog2(DIV_W + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_USAGE = 2'd2,
    CMD_INIT  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_ROOM   = 2'd1,
    STAT_NOT_READY = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE_LOG2 = 1'b0,
    REG_TABLE_ENTRIES   = 1'b1
  } cfg_reg_t;

endpackage

@@ rtl/core/block_table_allocator.sv @@
// Block table allocator: first-fit block allocation over several pools.
// Holds all block tables in one synchronous memory; depends on bta_pkg.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the block size
//   log2 (index 0) and the table length per bank (index 1); always ready.
//   in channel carries one command (allocate, free, usage, init bank); the
//   out channel returns exactly one result transaction per command.
// Operation (one command at a time, bound by the single table
// memory port pair, one entry touched per cycle):
//   allocate : scan of up to len entries plus one write per granted block
//   free     : read of the run length, then clears the run of n entries
//   usage    : entry count over len entries, then a radix-2 divider
//   init     : clears the bank's whole table
//   bad bank, zero size, range errors: result without any table access
// Reset: after rst the whole memory is cleared, one entry per cycle,
//   all MEM_DEPTH (1280) entries, with in_ready low; all banks start not ready.
// Stall: the result sits in an output register; the next command is taken
//   while it waits, and a later result waits in the core until it drains.
`timescale 1ns / 1ps

module block_table_allocator
  import bta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // command channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [BANK_W-1:0]    bank,
  input  logic [SIZE_W-1:0]    size,
  input  logic [SIZE_W-1:0]    offset,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    status,
  output logic [SIZE_W-1:0]    alloc_offset,
  output logic [PERM_W-1:0]    usage_permille
);

  typedef enum logic [9:0] {
    ST_CLEAR      = 10'b00_0000_0001,
    ST_IDLE       = 10'b00_0000_0010,
    ST_ALLOC_SCAN = 10'b00_0000_0100,
    ST_FREE_RD    = 10'b00_0000_1000,
    ST_FREE_LEN   = 10'b00_0001_0000,
    ST_USE_SCAN   = 10'b00_0010_0000,
    ST_DIV        = 10'b00_0100_0000,
    ST_WRITE      = 10'b00_1000_0000,
    ST_DONE       = 10'b01_0000_0000,
    ST_SPARE      = 10'b10_0000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [LG_W-1:0] block_size_log2;
  logic [TE_W-1:0] table_entries;

  // per-bank ready flags
  logic [NUM_BANKS-1:0] bank_ready;

  // table memory
  logic [ENT_W-1:0]  table_mem [MEM_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic [ENT_W-1:0]  rd_data;

  // command context
  logic [BANK_W-1:0] bank_q;
  logic [NEED_W-1:0] need_q;

  // read sequencing
  logic [IDX_W-1:0] rd_idx;
  logic             rd_act;
  logic [IDX_W-1:0] chk_idx;
  logic             chk_valid;
  logic [LEN_W-1:0] run;
  logic [LEN_W-1:0] used;

  // write sequencing
  logic [IDX_W-1:0]  wr_idx;
  logic [LEN_W-1:0]  wr_left;
  logic [ENT_W-1:0]  wr_val;
  logic [ADDR_W-1:0] clr_addr;

  // divider
  logic [DIV_W-1:0]  dvd;
  logic [LEN_W-1:0]  rem;
  logic [DCNT_W-1:0] dcnt;

  // pending result
  status_t          res_status;
  logic [SIZE_W-1:0] res_aoff;
  logic [PERM_W-1:0] res_perm;

  // effective configuration
  logic [LG_W-1:0]  lg;
  logic [LEN_W-1:0] len;

  // combinational helpers
  logic              bank_ok;
  logic [SIZE_W-1:0] size_mask;
  logic [NEED_W-1:0] need;
  logic [LIM_W-1:0]  limit;
  logic              off_range;
  logic [IDX_W-1:0]  free_idx;
  logic [LEN_W-1:0]  run_next;
  logic [LEN_W-1:0]  used_next;
  logic [LEN_W-1:0]  room;
  logic [LEN_W-1:0]  run_len;
  logic [AOFF_W-1:0] aoff_wide;
  logic [LEN_W:0]    rem_sh;
  logic              rem_ge;
  logic              out_load;

  function automatic logic [ADDR_W-1:0] tab_addr(input logic [BANK_W-1:0] b,
                                                 input logic [IDX_W-1:0]  i);
    tab_addr = ADDR_W'(b) * ADDR_W'(TABLE_DEPTH) + ADDR_W'(i);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  // saturate the configuration registers
  always_comb begin
    lg = (block_size_log2 > LG_W'(MAX_BS_LOG2)) ? LG_W'(MAX_BS_LOG2) : block_size_log2;
    if (table_entries == '0) begin
      len = LEN_W'(1);
    end else if (int'(table_entries) > TABLE_DEPTH) begin
      len = LEN_W'(TABLE_DEPTH);
    end else begin
      len = LEN_W'(table_entries);
    end
  end

  // request decode: block count, range check, block index
  always_comb begin
    bank_ok   = int'(bank) < NUM_BANKS;
    size_mask = (SIZE_W'(1) << lg) - SIZE_W'(1);
    need      = NEED_W'(size >> lg) + NEED_W'(|(size & size_mask));
    limit     = LIM_W'(len) << lg;
    off_range = OCMP_W'(offset) >= OCMP_W'(limit);
    free_idx  = IDX_W'(offset >> lg);
  end

  // scan, free and divider datapath
  always_comb begin
    run_next  = (rd_data == '0) ? run + LEN_W'(1) : '0;
    used_next = used + LEN_W'(rd_data != '0);
    room      = len - LEN_W'(rd_idx);
    run_len   = (rd_data > room) ? room : rd_data;
    aoff_wide = AOFF_W'(chk_idx) << lg;
    rem_sh    = {rem, dvd[DIV_W-1]};
    rem_ge    = rem_sh >= {1'b0, len};
  end

  // memory port control
  always_comb begin
    mem_raddr = tab_addr(bank_q, rd_idx);
    mem_we    = (state == ST_WRITE) || (state == ST_CLEAR);
    mem_waddr = (state == ST_CLEAR) ? clr_addr : tab_addr(bank_q, wr_idx);
    mem_wdata = (state == ST_CLEAR) ? '0 : wr_val;
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= table_mem[mem_raddr];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size_log2 <= LG_W'(6);
      table_entries   <= TE_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BLOCK_SIZE_LOG2: block_size_log2 <= cfg_data[LG_W-1:0];
        REG_TABLE_ENTRIES:   table_entries   <= cfg_data[TE_W-1:0];
        default: ;
      endcase
    end
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      bank_ready <= '0;
      rd_act     <= 1'b0;
      chk_valid  <= 1'b0;
    end else begin
      case (state)
        // clear the whole table memory after reset
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end

        // take a command transaction
        ST_IDLE: begin
          if (in_valid) begin
            bank_q     <= bank;
            need_q     <= need;
            res_status <= STAT_OK;
            res_aoff   <= '0;
            res_perm   <= '0;
            chk_valid  <= 1'b0;
            if (!bank_ok) begin
              res_status <= STAT_NOT_READY;
              state      <= ST_DONE;
            end else begin
              case (cmd_t'(cmd))
                CMD_ALLOC: begin
                  // a bank not yet ready still holds its cleared table
                  bank_ready[bank] <= 1'b1;
                  if (size == '0) begin
                    res_status <= STAT_NO_ROOM;
                    state      <= ST_DONE;
                  end else begin
                    rd_idx <= IDX_W'(len - LEN_W'(1));
                    rd_act <= 1'b1;
                    run    <= '0;
                    state  <= ST_ALLOC_SCAN;
                  end
                end
                CMD_FREE: begin
                  if (!bank_ready[bank]) begin
                    bank_ready[bank] <= 1'b1;
                    res_status       <= STAT_NOT_READY;
                    state            <= ST_DONE;
                  end else if (off_range) begin
                    res_status <= STAT_RANGE;
                    state      <= ST_DONE;
                  end else begin
                    rd_idx <= free_idx;
                    state  <= ST_FREE_RD;
                  end
                end
                CMD_USAGE: begin
                  rd_idx <= '0;
                  rd_act <= 1'b1;
                  used   <= '0;
                  state  <= ST_USE_SCAN;
                end
                default: begin
                  bank_ready[bank] <= 1'b1;
                  wr_idx  <= '0;
                  wr_left <= LEN_W'(TABLE_DEPTH);
                  wr_val  <= '0;
                  state   <= ST_WRITE;
                end
              endcase
            end
          end
        end

        // top-down first-fit scan, each check in the cycle after its read
        ST_ALLOC_SCAN: begin
          if (rd_act) begin
            rd_idx <= rd_idx - IDX_W'(1);
            rd_act <= (rd_idx != '0);
          end
          chk_valid <= rd_act;
          chk_idx   <= rd_idx;
          if (chk_valid) begin
            run <= run_next;
            if (NEED_W'(run_next) == need_q) begin
              rd_act   <= 1'b0;
              wr_idx   <= chk_idx;
              wr_left  <= LEN_W'(need_q);
              wr_val   <= ENT_W'(need_q);
              res_aoff <= SIZE_W'(aoff_wide);
              state    <= ST_WRITE;
            end else if (chk_idx == '0) begin
              rd_act     <= 1'b0;
              res_status <= STAT_NO_ROOM;
              state      <= ST_DONE;
            end
          end
        end

        // read the run length at the freed block
        ST_FREE_RD: begin
          state <= ST_FREE_LEN;
        end

        // clamp the run to the table end and clear it
        ST_FREE_LEN: begin
          if (run_len == '0) begin
            state <= ST_DONE;
          end else begin
            wr_idx  <= rd_idx;
            wr_left <= run_len;
            wr_val  <= '0;
            state   <= ST_WRITE;
          end
        end

        // count used entries in the first len entries
        ST_USE_SCAN: begin
          if (rd_act) begin
            rd_idx <= rd_idx + IDX_W'(1);
            rd_act <= (rd_idx != IDX_W'(len - LEN_W'(1)));
          end
          chk_valid <= rd_act;
          chk_idx   <= rd_idx;
          if (chk_valid) begin
            used <= used_next;
            if (chk_idx == IDX_W'(len - LEN_W'(1))) begin
              dvd   <= DIV_W'(used_next) * DIV_W'(PERMILLE);
              rem   <= '0;
              dcnt  <= DCNT_W'(DIV_W);
              state <= ST_DIV;
            end
          end
        end

        // restoring divide by len, one quotient bit per cycle
        ST_DIV: begin
          rem  <= rem_ge ? LEN_W'(rem_sh - {1'b0, len}) : LEN_W'(rem_sh);
          dvd  <= {dvd[DIV_W-2:0], rem_ge};
          dcnt <= dcnt - DCNT_W'(1);
          if (dcnt == DCNT_W'(1)) begin
            res_perm <= PERM_W'({dvd[DIV_W-2:0], rem_ge});
            state    <= ST_DONE;
          end
        end

        // write a run of entries, one per cycle
        ST_WRITE: begin
          wr_idx  <= wr_idx + IDX_W'(1);
          wr_left <= wr_left - LEN_W'(1);
          if (wr_left == LEN_W'(1)) begin
            state <= ST_DONE;
          end
        end

        // hand the result to the output register once it is free
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= res_status;
      alloc_offset   <= res_aoff;
      usage_permille <= res_perm;
    end
  end

  // no command is taken while the memory is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("command accepted during table clear");

  // a run write never starts empty
  a_write_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (wr_left != '0))
    else $error("run write with zero length");

  // a free run never grows past the table length
  a_run_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALLOC_SCAN) |-> (run <= len))
    else $error("free run longer than table");

  // results only come out of the done state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result without a finished command");

  // usage never exceeds a full table
  a_usage_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (usage_permille <= PERM_W'(PERMILLE)))
    else $error("usage above one thousand");

endmodule

@@ sim/block_table_allocator_tb.sv @@
// Self-checking testbench for block_table_allocator: directed and random commands
// against a first-fit block table predictor kept in a small scoreboard class.
// Depends on bta_pkg and block_table_allocator.
`timescale 1ns / 1ps

module block_table_allocator_tb;
  import bta_pkg::*;

  localparam int CYCLE_LIMIT    = 3000000;
  localparam int TAIL_CYCLES    = 2 * TABLE_DEPTH + 64;
  localparam int SQUEEZE_CYCLES = 3000;
  localparam int NUM_PHASES     = 14;
  localparam int PHASE_ITEMS    = 80;

  // one expected result transaction
  typedef struct packed {
    status_t             st;
    logic [SIZE_W-1:0]   aoff;
    logic [PERM_W-1:0]   perm;
  } alloc_result_t;

  // a region handed out by a successful allocate
  typedef struct {
    int unsigned bk;
    int unsigned ofs;
  } grant_t;

  // block table predictor and queue of results still owed by the block
  class alloc_scoreboard;
    logic [ENT_W-1:0] blk_tbl [NUM_BANKS][TABLE_DEPTH];
    bit               bank_up [NUM_BANKS];
    logic [LG_W-1:0]  lg_reg;
    logic [TE_W-1:0]  te_reg;
    alloc_result_t    pending_results [$];
    int               errors;

    function new();
      for (int b = 0; b < NUM_BANKS; b++) begin
        for (int i = 0; i < TABLE_DEPTH; i++) blk_tbl[b][i] = '0;
        bank_up[b] = 1'b0;
      end
      lg_reg = 4'd6;
      te_reg = 9'd256;
      errors = 0;
    endfunction

    function int unsigned block_log2();
      return (lg_reg > MAX_BS_LOG2) ? MAX_BS_LOG2 : lg_reg;
    endfunction

    function int unsigned table_len();
      if (te_reg == 0) return 1;
      if (te_reg > TABLE_DEPTH) return TABLE_DEPTH;
      return te_reg;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      if (idx == REG_BLOCK_SIZE_LOG2) lg_reg = val[LG_W-1:0];
      else te_reg = val[TE_W-1:0];
    endfunction

    function void open_bank(int unsigned b);
      for (int i = 0; i < TABLE_DEPTH; i++) blk_tbl[b][i] = '0;
      bank_up[b] = 1'b1;
    endfunction

    // apply one accepted command and queue the result it must produce
    function alloc_result_t note_command(cmd_t c, int unsigned b, int unsigned sz,
                                         int unsigned ofs);
      alloc_result_t r;
      int unsigned   lg, len, need, run, cnt, idx, n;
      int            k;
      r.st   = STAT_OK;
      r.aoff = '0;
      r.perm = '0;
      lg  = block_log2();
      len = table_len();
      if (b >= NUM_BANKS) begin
        r.st = STAT_NOT_READY;
      end else begin
        case (c)
          CMD_ALLOC: begin
            if (!bank_up[b]) open_bank(b);
            need = (sz + (32'd1 << lg) - 1) >> lg;
            run  = 0;
            r.st = STAT_NO_ROOM;
            // first fit, scanning from the top entry down
            if (sz != 0) begin
              for (k = len - 1; k >= 0 && r.st != STAT_OK; k--) begin
                if (blk_tbl[b][k] == '0) run++;
                else run = 0;
                if (run == need) begin
                  for (n = 0; n < need; n++) blk_tbl[b][k + n] = ENT_W'(need);
                  r.st   = STAT_OK;
                  r.aoff = SIZE_W'(k << lg);
                end
              end
            end
          end
          CMD_FREE: begin
            if (!bank_up[b]) begin
              open_bank(b);
              r.st = STAT_NOT_READY;
            end else if (ofs >= (len << lg)) begin
              r.st = STAT_RANGE;
            end else begin
              // clear the recorded run, stopping at the table end
              idx = ofs >> lg;
              n   = blk_tbl[b][idx];
              if (n > len - idx) n = len - idx;
              for (cnt = 0; cnt < n; cnt++) blk_tbl[b][idx + cnt] = '0;
            end
          end
          CMD_USAGE: begin
            cnt = 0;
            for (idx = 0; idx < len; idx++) if (blk_tbl[b][idx] != '0) cnt++;
            r.perm = PERM_W'((cnt * PERMILLE) / len);
          end
          CMD_INIT: begin
            open_bank(b);
          end
        endcase
      end
      pending_results.push_back(r);
      return r;
    endfunction

    // compare one result transaction with the oldest expectation
    function void check_result(logic [STAT_W-1:0] st, logic [SIZE_W-1:0] ao,
                               logic [PERM_W-1:0] pm);
      alloc_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d alloc_offset %0d usage_permille %0d",
               st, ao, pm);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (st !== e.st) begin
        $error("status: expected %0d, actual %0d", e.st, st);
        errors++;
      end
      if (ao !== e.aoff) begin
        $error("alloc_offset: expected %0d, actual %0d", e.aoff, ao);
        errors++;
      end
      if (pm !== e.perm) begin
        $error("usage_permille: expected %0d, actual %0d", e.perm, pm);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd;
  logic [BANK_W-1:0]    bank;
  logic [SIZE_W-1:0]    size;
  logic [SIZE_W-1:0]    offset;
  logic                 out_valid;
  logic                 out_ready;
  logic [STAT_W-1:0]    status;
  logic [SIZE_W-1:0]    alloc_offset;
  logic [PERM_W-1:0]    usage_permille;

  alloc_scoreboard sb;
  grant_t          grants [$];
  bit              idle_on;
  bit              squeeze_req;
  int              cycles;

  block_table_allocator dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .bank           (bank),
    .size           (size),
    .offset         (offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .alloc_offset   (alloc_offset),
    .usage_permille (usage_permille)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("block_table_allocator test failed");
    $finish;
  end

  // result side: check each transaction, stall in bursts, one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(status, alloc_offset, usage_permille);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (squeeze_req) begin
        squeeze_req = 1'b0;
        stall_left  = SQUEEZE_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one register write transaction; the caller lowers cfg_valid
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  // block size with junk in the unused upper data bits, then table length
  task automatic configure(int unsigned lg, int unsigned te);
    logic [CFG_W-LG_W-1:0] junk;
    junk = (CFG_W-LG_W)'($urandom);
    write_reg(REG_BLOCK_SIZE_LOG2, {junk, lg[LG_W-1:0]});
    write_reg(REG_TABLE_ENTRIES, te[TE_W-1:0]);
    cfg_valid <= 1'b0;
  endtask

  // one command transaction, with an optional gap in front
  task automatic send_cmd(cmd_t c, logic [BANK_W-1:0] b, logic [SIZE_W-1:0] sz,
                          logic [SIZE_W-1:0] ofs);
    int            gap;
    alloc_result_t res;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    bank     <= b;
    size     <= sz;
    offset   <= ofs;
    do @(posedge clk); while (!in_ready);
    res = sb.note_command(c, b, sz, ofs);
    if (c == CMD_ALLOC && b < NUM_BANKS && res.st == STAT_OK)
      grants.push_back('{bk: b, ofs: res.aoff});
  endtask

  // stop offering and wait for every owed result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  // mostly well-formed allocate/free traffic with usage and init commands, some noise
  task automatic random_command();
    int unsigned lg, len, span, b, sz, ofs, need, pick, sel;
    cmd_t        c;
    lg   = sb.block_log2();
    len  = sb.table_len();
    span = len << lg;
    b    = ($urandom_range(0, 19) == 0) ? $urandom_range(NUM_BANKS, 7)
                                        : $urandom_range(0, NUM_BANKS - 1);
    sz   = $urandom & 24'hFFFFFF;
    ofs  = $urandom & 24'hFFFFFF;
    sel  = $urandom_range(0, 99);
    if (sel < 45) begin
      c    = CMD_ALLOC;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        sz = 0;
      end else if (pick > 1) begin
        // keep most requests small so the tables do not fill at once
        if (len > 8 && pick < 9) need = $urandom_range(1, len / 4 + 1);
        else need = $urandom_range(1, len);
        sz = ((need - 1) << lg) + $urandom_range(1, 32'd1 << lg);
      end
    end else if (sel < 75) begin
      c    = CMD_FREE;
      pick = $urandom_range(0, 9);
      if (pick < 6 && grants.size() > 0) begin
        sel = $urandom_range(0, grants.size() - 1);
        b   = grants[sel].bk;
        ofs = grants[sel].ofs;
        if ($urandom_range(0, 3) == 0) ofs += $urandom_range(0, (32'd1 << lg) - 1);
        grants.delete(sel);
      end else if (pick < 8) begin
        ofs = $urandom_range(0, span - 1);
      end else if (pick == 8) begin
        ofs = $urandom_range(span, 24'hFFFFFF);
      end
    end else if (sel < 93) begin
      c = CMD_USAGE;
    end else begin
      c = CMD_INIT;
    end
    send_cmd(c, BANK_W'(b), SIZE_W'(sz), SIZE_W'(ofs));
  endtask

  // main sequence
  initial begin
    int unsigned lg_set [8];
    int unsigned te_set [8];
    int unsigned lg, te;
    sb          = new();
    idle_on     = 1'b1;
    squeeze_req = 1'b0;
    lg_set      = '{0, 12, 15, 3, 6, 13, 1, 9};
    te_set      = '{1, 2, 511, 16, 256, 0, 300, 24};
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_BLOCK_SIZE_LOG2;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    cmd       <= CMD_USAGE;
    bank      <= '0;
    size      <= '0;
    offset    <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset register values, 64-byte blocks, full tables
    send_cmd(CMD_USAGE, 0, 0, 0);
    send_cmd(CMD_FREE,  1, 0, 0);
    send_cmd(CMD_ALLOC, 0, 0, 0);
    send_cmd(CMD_ALLOC, 0, 1, 0);
    send_cmd(CMD_ALLOC, 0, 24'hFFFFFF, 0);
    send_cmd(CMD_ALLOC, 5, 64, 0);
    send_cmd(CMD_USAGE, 7, 0, 24'hFFFFFF);
    send_cmd(CMD_FREE,  0, 0, 24'hFFFFFF);
    send_cmd(CMD_FREE,  0, 0, 255 * 64 + 63);
    send_cmd(CMD_FREE,  0, 0, 255 * 64);
    send_cmd(CMD_INIT,  4, 0, 0);
    send_cmd(CMD_ALLOC, 2, 256 * 64, 0);
    send_cmd(CMD_USAGE, 2, 0, 0);
    send_cmd(CMD_ALLOC, 2, 1, 0);
    send_cmd(CMD_FREE,  2, 0, 100 * 64);
    send_cmd(CMD_USAGE, 2, 0, 0);
    send_cmd(CMD_ALLOC, 3, 8 * 64, 0);
    drain();

    // shrink the table under a run so that freeing it clamps at the end
    configure(0, 250);
    send_cmd(CMD_FREE,  3, 0, 248);
    send_cmd(CMD_USAGE, 3, 0, 0);
    send_cmd(CMD_ALLOC, 3, 250, 0);
    drain();

    // saturating register values: largest block, single entry table
    configure(15, 0);
    send_cmd(CMD_ALLOC, 4, 4096, 0);
    send_cmd(CMD_USAGE, 4, 0, 0);
    send_cmd(CMD_FREE,  4, 0, 4096);
    send_cmd(CMD_FREE,  4, 0, 4095);

    // random phases, each under its own configuration
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if (ph < 8) begin
        lg = lg_set[ph];
        te = te_set[ph];
      end else begin
        lg = $urandom_range(0, 15);
        te = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 511) : $urandom_range(1, 40);
      end
      if (ph == NUM_PHASES - 1) idle_on = 1'b0;
      configure(lg, te);
      grants.delete();
      if (ph == 3) squeeze_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) random_command();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("block_table_allocator test passed");
    end else begin
      $display("block_table_allocator test failed");
    end
    $finish;
  end

endmodule
